// File: src/fingerprint_candidate_block_rule_core_defines.svh
// ----------------------------------------------------------------------------
// fingerprint_candidate_block_rule_core_defines
// Assertion macros used by the checker file of the candidate block rule.
// ----------------------------------------------------------------------------
`ifndef FINGERPRINT_CANDIDATE_BLOCK_RULE_CORE_DEFINES_SVH
`define FINGERPRINT_CANDIDATE_BLOCK_RULE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCBR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FCBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/fcbr_pkg.sv
// ----------------------------------------------------------------------------
// fcbr_pkg
// Types and constants shared by the candidate block rule modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fcbr_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned ApbAw  = 2;

  // Register map
  localparam logic [ApbAw-1:0] RegSensorTypeCode = 2'd0;

  localparam logic [DataW-1:0] SensorTypeCodeRst = 32'd12;

  // Request codes
  localparam logic ReqEvaluate = 1'b0;
  localparam logic ReqClear    = 1'b1;

  // Detail adjustment
  localparam logic signed [DataW-1:0] AdjDefault    = -32'sd20;
  localparam logic signed [DataW-1:0] AdjLowScore   = -32'sd10;
  localparam logic signed [DataW-1:0] AdjNone       = 32'sd0;
  localparam logic signed [DataW-1:0] ScoreAbsent   = -32'sd1;
  localparam logic signed [DataW-1:0] ScoreLow      = 32'sd70;
  localparam logic signed [DataW-1:0] ScoreVeryLow  = 32'sd60;
  localparam logic signed [DataW-1:0] ScoreEdge     = 32'sd75;
  localparam logic signed [DataW-1:0] BoundaryLarge = 32'sd100;

  // Override thresholds
  localparam logic signed [DataW-1:0] OvrCountLo = 32'sd5;
  localparam logic signed [DataW-1:0] OvrCountHi = 32'sd10;

  typedef struct packed {
    logic                    req_type;
    logic [DataW-1:0]        sensor_type;
    logic signed [DataW-1:0] tex_diff;
    logic signed [DataW-1:0] form_diff;
    logic signed [DataW-1:0] rim_diff;
    logic signed [DataW-1:0] rim_score;
    logic signed [DataW-1:0] cand_cov;
    logic signed [DataW-1:0] matched_pairs;
    logic signed [DataW-1:0] pair_cov;
    logic signed [DataW-1:0] supp_ratio;
    logic signed [DataW-1:0] detail_metric;
  } fcbr_item_t;

  typedef struct packed {
    logic                    clear;
    logic                    matched;
    logic                    blocked;
    logic signed [DataW-1:0] metric;
  } fcbr_eval_t;

endpackage

`default_nettype wire

// File: src/fingerprint_candidate_block_rule_core.sv
// ----------------------------------------------------------------------------
// fingerprint_candidate_block_rule_core
// Candidate block rule with a running blocking tally and APB register port.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  in       | input     | in_valid_i/in_stall_o | req_type_i .. detail_metric_i
//  out      | output    | out_valid_o/out_stall_i | type_matched_o .. override_flag_o
//  cfg      | input     | psel/penable/pready  | sensor_type_code at 0x0
//
//  One item per cycle sustained while the output is not stalled; an accepted
//  transaction passes the input register, then result register and tally update.
//  The tally registers hold the count and sum reported with the current result.
//  A stalled output holds; the input register still takes one more item.
//  Reset clears the tally and sets sensor_type_code to 12.
// ----------------------------------------------------------------------------
`default_nettype none

module fingerprint_candidate_block_rule_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic [fcbr_pkg::DataW-1:0]        sensor_type_i,
  input  logic signed [fcbr_pkg::DataW-1:0] tex_diff_i,
  input  logic signed [fcbr_pkg::DataW-1:0] form_diff_i,
  input  logic signed [fcbr_pkg::DataW-1:0] rim_diff_i,
  input  logic signed [fcbr_pkg::DataW-1:0] rim_score_i,
  input  logic signed [fcbr_pkg::DataW-1:0] cand_cov_i,
  input  logic signed [fcbr_pkg::DataW-1:0] matched_pairs_i,
  input  logic signed [fcbr_pkg::DataW-1:0] pair_cov_i,
  input  logic signed [fcbr_pkg::DataW-1:0] supp_ratio_i,
  input  logic signed [fcbr_pkg::DataW-1:0] detail_metric_i,
  // Output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              type_matched_o,
  output logic                              blocked_o,
  output logic signed [fcbr_pkg::DataW-1:0] block_detail_o,
  output logic signed [fcbr_pkg::DataW-1:0] blocking_count_o,
  output logic signed [fcbr_pkg::DataW-1:0] blocking_sum_o,
  output logic                              override_flag_o,
  // Register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fcbr_pkg::ApbAw-1:0]        paddr,
  input  logic [fcbr_pkg::DataW-1:0]        pwdata,
  output logic [fcbr_pkg::DataW-1:0]        prdata,
  output logic                              pready
);
  import fcbr_pkg::*;

  logic              in_valid_q;
  fcbr_item_t        item_q;
  logic              out_valid_q;
  logic              type_matched_q;
  logic              blocked_q;
  logic signed [DataW-1:0] metric_q;
  logic [DataW-1:0]  sensor_type_code_q;
  logic              out_ready;
  logic              advance;
  logic              in_take;
  fcbr_eval_t        eval;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr == RegSensorTypeCode) ? sensor_type_code_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_type_code_q <= SensorTypeCodeRst;
    end else if (psel && penable && pwrite && pready && paddr == RegSensorTypeCode) begin
      sensor_type_code_q <= pwdata;
    end
  end

  // Flow control: result register frees when empty or taken.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.req_type      <= req_type_i;
      item_q.sensor_type   <= sensor_type_i;
      item_q.tex_diff      <= tex_diff_i;
      item_q.form_diff     <= form_diff_i;
      item_q.rim_diff      <= rim_diff_i;
      item_q.rim_score     <= rim_score_i;
      item_q.cand_cov      <= cand_cov_i;
      item_q.matched_pairs <= matched_pairs_i;
      item_q.pair_cov      <= pair_cov_i;
      item_q.supp_ratio    <= supp_ratio_i;
      item_q.detail_metric <= detail_metric_i;
    end
  end

  fcbr_rule u_rule (
    .item_i             (item_q),
    .sensor_type_code_i (sensor_type_code_q),
    .eval_o             (eval)
  );

  fcbr_tally u_tally (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .eval_i     (eval),
    .count_o    (blocking_count_o),
    .sum_o      (blocking_sum_o),
    .override_o (override_flag_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      type_matched_q <= eval.matched;
      blocked_q      <= eval.blocked;
      metric_q       <= eval.metric;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign type_matched_o = type_matched_q;
  assign blocked_o      = blocked_q;
  assign block_detail_o = metric_q;

endmodule

`default_nettype wire

// File: src/fcbr_rule.sv
// ----------------------------------------------------------------------------
// fcbr_rule
// Type match, threshold rule and detail adjustment for one registered item.
// ----------------------------------------------------------------------------
`default_nettype none

module fcbr_rule (
  input  fcbr_pkg::fcbr_item_t         item_i,
  input  logic [fcbr_pkg::DataW-1:0]   sensor_type_code_i,
  output fcbr_pkg::fcbr_eval_t         eval_o
);
  import fcbr_pkg::*;

  logic signed [DataW-1:0] t, s, bd, bs, cc, pc, pv, sr, d;
  logic signed [DataW-1:0] adj;
  logic                    hit;
  logic                    matched;

  assign t  = item_i.tex_diff;
  assign s  = item_i.form_diff;
  assign bd = item_i.rim_diff;
  assign bs = item_i.rim_score;
  assign cc = item_i.cand_cov;
  assign pc = item_i.matched_pairs;
  assign pv = item_i.pair_cov;
  assign sr = item_i.supp_ratio;
  assign d  = item_i.detail_metric;

  // Compares use the raw detail value.
  always_comb begin
    hit = (s > 415 && bd > 318) ||
          (s >= 358 && bd >= 581) ||
          (t >= 27 && s > 236 && bd > 315 && bs >= 95 && pc >= 6) ||
          (t >= 15 && s >= 295 && bd >= 320 && bs >= 93 && cc > 95 && sr >= 3200) ||
          (t >= 27 && s >= 350 && pc >= 29) ||
          (t >= 25 && s >= 370 && bd >= 450 && bs >= 88 && pc >= 10 && pv <= 1900) ||
          (t >= 90 && s >= 95 && bd >= 250 && bs >= 85 && pc >= 20 && d > 77) ||
          (t >= 88 && s >= 130 && bd >= 280 && cc >= 80 && pc >= 3 && d <= 78 &&
           pv <= 1700 && sr >= 2700) ||
          (t >= 33 && s >= 220 && bs >= 90 && cc >= 71 && pc >= 2 && d <= 78 &&
           pv <= 1070 && sr >= 3399) ||
          (t >= 80 && s >= 50 && bd >= 120 && bs >= 93 && cc >= 100 && pc <= 12 &&
           d <= 75 && pv <= 920 && sr >= 3990) ||
          (t >= 20 && s >= 290 && bs >= 90 && pc >= 7 && pv <= 1024) ||
          (t >= 70 && s >= 340 && bd >= 400 && bs >= 95) ||
          (t >= 54 && s >= 145 && bd >= 210 && bs <= 88 && cc >= 150 && pc >= 21) ||
          (t >= 24 && bd >= 245 && bs <= 88 && pc >= 9 && sr <= 930) ||
          (t >= 57 && s >= 147 && bd >= 229 && bs <= 88 && cc >= 105 && pc >= 9 &&
           sr >= 3750) ||
          (t >= 33 && s >= 100 && bd >= 230 && bs >= 89 && d >= 70 && pc >= 9 &&
           pv <= 1470 && sr >= 4600) ||
          (t >= 40 && s <= -240 && bd <= -220 && bs <= 91 && d >= 70 && pc >= 10 &&
           pv <= 1402 && sr <= 3670) ||
          (t >= 23 &&
           ((s >= 271 && bd >= 288 && bs >= 92 && cc >= 163) ||
            (s >= 280 && bd >= 287 && bs >= 90 && cc <= 161 && d >= 69 &&
             sr >= 2800))) ||
          (bd >= 420 && pv <= 670 && sr >= 1000) ||
          (s >= 380 && bd >= 480 && sr <= 1000) ||
          (t >= 56 && s >= 220 && bd >= 289 && cc >= 141) ||
          (t >= 19 && s >= 280 && bd >= 350 && bs <= 95 && cc >= 170) ||
          (t >= 40 && bd >= 480 && pc <= 0) ||
          (t >= 120 && s >= 100 && bd >= 270 && bs >= 87 && pc >= 8 && d > 76) ||
          (t >= 30 && bd >= 420 && bs >= 90 && pv <= 1700 && sr >= 2200) ||
          (t >= 45 && s >= 170 && bd >= 290 && bs >= 95 && pc >= 10) ||
          (t >= 20 && s >= 180 && bd >= 260 && bs >= 85 && pv <= 1000 && sr >= 3500);
  end

  always_comb begin
    adj = AdjDefault;
    if (bs != ScoreAbsent) begin
      if (bs < ScoreLow) begin
        adj = AdjLowScore;
      end
      if (bs < ScoreVeryLow || (bd > BoundaryLarge && bs < ScoreEdge)) begin
        adj = AdjNone;
      end
    end
  end

  assign matched = (item_i.req_type == ReqEvaluate) &&
                   (item_i.sensor_type == sensor_type_code_i);

  always_comb begin
    eval_o.clear   = (item_i.req_type == ReqClear);
    eval_o.matched = matched;
    eval_o.blocked = matched && hit;
    eval_o.metric  = (matched && hit) ? d + adj : '0;
  end

endmodule

`default_nettype wire

// File: src/fcbr_tally.sv
// ----------------------------------------------------------------------------
// fcbr_tally
// Running blocked count and sum, with the override decision on the tally.
// ----------------------------------------------------------------------------
`default_nettype none

module fcbr_tally (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              advance_i,
  input  fcbr_pkg::fcbr_eval_t              eval_i,
  output logic signed [fcbr_pkg::DataW-1:0] count_o,
  output logic signed [fcbr_pkg::DataW-1:0] sum_o,
  output logic                              override_o
);
  import fcbr_pkg::*;

  logic signed [DataW-1:0] count_q, count_d;
  logic signed [DataW-1:0] sum_q, sum_d;
  logic signed [DataW-1:0] count_x60;
  logic signed [DataW-1:0] count_x50;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    if (advance_i) begin
      if (eval_i.clear) begin
        count_d = '0;
        sum_d   = '0;
      end else if (eval_i.blocked) begin
        count_d = count_q + 32'sd1;
        sum_d   = sum_q + eval_i.metric;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  // Wrapped products as shift-add: 60 = 64 - 4, 50 = 32 + 16 + 2.
  assign count_x60 = (count_q <<< 6) - (count_q <<< 2);
  assign count_x50 = (count_q <<< 5) + (count_q <<< 4) + (count_q <<< 1);

  assign override_o = (count_q > OvrCountLo && sum_q > count_x60) ||
                      (count_q > OvrCountHi && sum_q > count_x50);

  assign count_o = count_q;
  assign sum_o   = sum_q;

endmodule

`default_nettype wire

// File: src/fcbr_checker.sv
// ----------------------------------------------------------------------------
// fcbr_checker
// Port-level checks on the candidate block rule, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fingerprint_candidate_block_rule_core_defines.svh"

module fcbr_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_stall_o,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic                              type_matched_o,
  input  logic                              blocked_o,
  input  logic signed [fcbr_pkg::DataW-1:0] block_detail_o,
  input  logic signed [fcbr_pkg::DataW-1:0] blocking_count_o,
  input  logic signed [fcbr_pkg::DataW-1:0] blocking_sum_o,
  input  logic                              override_flag_o,
  input  logic                              pready
);
  import fcbr_pkg::*;

  // Hold a stalled result.
  `FCBR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(blocking_count_o) && $stable(blocking_sum_o) && $stable(block_detail_o), "stalled result changed")

  // Stall the input only behind a stalled result.
  `FCBR_ASSERT_NOW(a_in_stall, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled with the output free")

  `FCBR_ASSERT_NOW(a_blocked_matched, clk_i, rst_ni, out_valid_o && blocked_o, type_matched_o, "blocked without a type match")

  `FCBR_ASSERT_NOW(a_metric_zero, clk_i, rst_ni, out_valid_o && !blocked_o, block_detail_o == '0, "metric set on an unblocked item")

  `FCBR_ASSERT_NOW(a_override_count, clk_i, rst_ni, out_valid_o && override_flag_o, blocking_count_o > OvrCountLo && pready, "override with a small count")

endmodule

bind fingerprint_candidate_block_rule_core fcbr_checker u_fcbr_checker (.*);

`default_nettype wire
